FILE: design/box_blur_3x3_edge_clipped_unit_defines.svh
// Assertion macros shared by the checker of the 3x3 box blur unit.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BB3_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bb3_pkg.sv
// Types, constants and the reciprocal table of the 3x3 box blur unit.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned ROW_W        = 13;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned PIX_W       = CHAN_W * NUM_CHAN;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned NUM_W       = SUM_W + 1;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned RECIP_W     = RECIP_SHIFT;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DPRIME,
    ST_DREAD,
    ST_SUM,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic px_load;
    logic rd_en;
    logic wr_en;
    logic shift_en;
    logic col_valid;
    logic col_clear;
    logic sum_en;
    logic mul_en;
    logic out_load;
    logic center_hi;
    logic top_ok;
    logic bottom_ok;
    logic last;
  } bb3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } bb3_status_t;

  // ceil(2^17 / (2 * cnt)); exact floor division for numerators up to 4599.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: design/bb3_ctrl.sv
// Controller of the 3x3 box blur unit: frame position, registers and sequencing.
module bb3_ctrl import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  bb3_status_t           status_i,
  output bb3_cmd_t              cmd_o,
  output logic [AW-1:0]         rd_addr_o,
  output logic [AW-1:0]         wr_addr_o
);

  state_e                  state_q, state_d;
  logic [WIDTH_REG_W-1:0]  width_q, width_d;
  logic [HEIGHT_REG_W-1:0] height_q, height_d;
  logic [AW-1:0]           col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [WW-1:0]           drain_q, drain_d;
  logic                    pend2_q, pend2_d;
  logic                    center_hi_q, center_hi_d;
  logic                    top_ok_q, top_ok_d;
  logic                    bottom_ok_q, bottom_ok_d;
  logic                    last_q, last_d;

  logic [WW-1:0]    w_used;
  logic [ROW_W-1:0] h_used;
  logic [WW-1:0]    drain_nxt;
  logic             col_last;
  logic             frame_in;
  logic             drain_ok;
  logic             drain_more;
  logic             drain_last;
  logic             res1;
  logic             res2;

  // Registers clamped to their usable ranges.
  always_comb begin
    if (width_q == '0) begin
      w_used = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_used = WW'(MAX_WIDTH);
    end else begin
      w_used = WW'(width_q);
    end
    if (height_q == '0) begin
      h_used = ROW_W'(1);
    end else if (32'(height_q) > HEIGHT_LIMIT) begin
      h_used = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_used = ROW_W'(height_q);
    end
  end

  // Position tests.
  assign col_last   = (WW'(col_q) + WW'(1)) == w_used;
  assign frame_in   = row_q < h_used;
  assign drain_nxt  = drain_q + WW'(1);
  assign drain_ok   = !frame_in && (drain_q < w_used);
  assign drain_more = drain_nxt < w_used;
  assign drain_last = drain_nxt == w_used;
  assign res1       = (row_q != '0) && (col_q != '0);
  assign res2       = (row_q != '0) && col_last;

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      col_q       <= '0;
      row_q       <= '0;
      drain_q     <= '0;
      pend2_q     <= 1'b0;
      center_hi_q <= 1'b0;
      top_ok_q    <= 1'b0;
      bottom_ok_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      drain_q     <= drain_d;
      pend2_q     <= pend2_d;
      center_hi_q <= center_hi_d;
      top_ok_q    <= top_ok_d;
      bottom_ok_q <= bottom_ok_d;
      last_q      <= last_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    drain_d     = drain_q;
    pend2_d     = pend2_q;
    center_hi_d = center_hi_q;
    top_ok_d    = top_ok_q;
    bottom_ok_d = bottom_ok_q;
    last_d      = last_q;
    cmd_o       = '0;
    rd_addr_o   = '0;
    wr_addr_o   = col_q;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          // Any register write restarts the frame.
          col_d   = '0;
          row_d   = '0;
          drain_d = '0;
          unique case (cfg_index_e'(cfg_index_i))
            CFG_IMAGE_WIDTH:  width_d  = cfg_data_i[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT: height_d = cfg_data_i[HEIGHT_REG_W-1:0];
            default: ;
          endcase
        end else if (in_valid_i) begin
          if (op_e'(in_op_i) == OP_PIXEL) begin
            // Pixels past the last row are dropped.
            if (frame_in) begin
              cmd_o.px_load = 1'b1;
              cmd_o.rd_en   = 1'b1;
              rd_addr_o     = col_q;
              state_d       = ST_READ;
            end
          end else if (drain_ok) begin
            cmd_o.rd_en = 1'b1;
            if (drain_q == '0) begin
              rd_addr_o = '0;
              state_d   = ST_DPRIME;
            end else begin
              rd_addr_o = drain_more ? drain_nxt[AW-1:0] : '0;
              state_d   = ST_DREAD;
            end
          end
        end
      end

      ST_READ: begin
        // Shift the window and update both line stores at this column.
        cmd_o.shift_en  = 1'b1;
        cmd_o.col_valid = 1'b1;
        cmd_o.col_clear = (col_q == '0);
        cmd_o.wr_en     = 1'b1;
        top_ok_d        = row_q >= ROW_W'(2);
        bottom_ok_d     = 1'b1;
        last_d          = 1'b0;
        center_hi_d     = !res1;
        pend2_d         = res1 && res2;
        if (col_last) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + AW'(1);
        end
        state_d = (res1 || res2) ? ST_SUM : ST_IDLE;
      end

      ST_DPRIME: begin
        // Load column zero for the first drain result.
        cmd_o.shift_en  = 1'b1;
        cmd_o.col_valid = 1'b1;
        cmd_o.col_clear = 1'b1;
        cmd_o.rd_en     = 1'b1;
        rd_addr_o       = drain_more ? drain_nxt[AW-1:0] : '0;
        state_d         = ST_DREAD;
      end

      ST_DREAD: begin
        cmd_o.shift_en  = 1'b1;
        cmd_o.col_valid = drain_more;
        center_hi_d     = 1'b0;
        top_ok_d        = h_used >= ROW_W'(2);
        bottom_ok_d     = 1'b0;
        last_d          = drain_last;
        pend2_d         = 1'b0;
        if (drain_last) begin
          col_d   = '0;
          row_d   = '0;
          drain_d = '0;
        end else begin
          drain_d = drain_nxt;
        end
        state_d = ST_SUM;
      end

      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_MUL;
      end

      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_EMIT;
      end

      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (pend2_q) begin
            // Row end: the result centered on the last column follows.
            pend2_d     = 1'b0;
            center_hi_d = 1'b1;
            state_d     = ST_SUM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    cmd_o.center_hi = center_hi_q;
    cmd_o.top_ok    = top_ok_q;
    cmd_o.bottom_ok = bottom_ok_q;
    cmd_o.last      = last_q;
  end

endmodule

FILE: design/bb3_datapath.sv
// Datapath of the 3x3 box blur unit: line stores, window, sums, divide, output register.
module bb3_datapath import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bb3_cmd_t         cmd_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] in_pixel_i,
  output bb3_status_t      status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_pixel_o,
  output logic             out_last_o
);

  logic [PIX_W-1:0]  line2_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  line1_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  rd2_q;
  logic [PIX_W-1:0]  rd1_q;
  logic [PIX_W-1:0]  px_q;
  logic [PIX_W-1:0]  win_q [3][3];
  logic [2:0]        colv_q, colv_d;
  logic [2:0]        row_ok;
  logic              use_cell;
  logic [SUM_W-1:0]  sum_d [NUM_CHAN];
  logic [SUM_W-1:0]  sum_q [NUM_CHAN];
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic [NUM_W-1:0]  num [NUM_CHAN];
  logic [PROD_W-1:0] prod_q [NUM_CHAN];
  logic [PIX_W-1:0]  out_pixel_q;
  logic              out_last_q;
  logic              out_valid_q;

  // Line stores: row r-2 and row r-1, one read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd2_q <= line2_mem[rd_addr_i];
      rd1_q <= line1_mem[rd_addr_i];
    end
    if (cmd_i.wr_en) begin
      line2_mem[wr_addr_i] <= rd1_q;
      line1_mem[wr_addr_i] <= px_q;
    end
  end

  // Incoming pixel and the 3x3 window, shifted one column left on each shift command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.px_load) begin
      px_q <= in_pixel_i;
    end
    if (cmd_i.shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd2_q;
      win_q[1][2] <= rd1_q;
      win_q[2][2] <= px_q;
    end
  end

  // Column valid flags follow the window; a row start clears the older columns.
  always_comb begin
    colv_d    = colv_q;
    if (cmd_i.shift_en) begin
      colv_d[0] = cmd_i.col_clear ? 1'b0 : colv_q[1];
      colv_d[1] = cmd_i.col_clear ? 1'b0 : colv_q[2];
      colv_d[2] = cmd_i.col_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colv_q <= '0;
    end else begin
      colv_q <= colv_d;
    end
  end

  // Masked channel sums and the count of in-frame cells.
  always_comb begin
    row_ok   = {cmd_i.bottom_ok, 1'b1, cmd_i.top_ok};
    cnt_d    = '0;
    use_cell = 1'b0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum_d[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        use_cell = row_ok[r] && colv_q[k] && (!cmd_i.center_hi || (k != 0));
        if (use_cell) begin
          cnt_d = cnt_d + CNT_W'(1);
          for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(win_q[r][k][ch*CHAN_W +: CHAN_W]);
          end
        end
      end
    end
  end

  // Rounded mean: (2*sum + cnt) / (2*cnt) through a reciprocal multiply.
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      num[ch] = {sum_q[ch], 1'b0} + NUM_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.mul_en) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        prod_q[ch] <= PROD_W'(num[ch]) * PROD_W'(recip_lookup(cnt_q));
      end
    end
    if (cmd_i.out_load) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        out_pixel_q[ch*CHAN_W +: CHAN_W] <= prod_q[ch][RECIP_SHIFT +: CHAN_W];
      end
      out_last_q <= cmd_i.last;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_pixel_o       = out_pixel_q;
  assign out_last_o        = out_last_q;

endmodule

FILE: design/box_blur_3x3_edge_clipped_unit.sv
// Top level of the 3x3 edge-clipped box blur unit.
// The block takes RGB pixels in raster order on the s_axis channel, one beat per
// pixel, with tuser low; a beat with tuser high is a flush tick. Results leave on
// m_axis, one beat each, as the rounded mean of the in-frame 3x3 neighborhood.
// Row r-1 is produced while row r arrives; a row-end pixel past column 0 yields two beats.
// After the frame, one flush tick per column drains the last row, and tlast
// marks the final beat, after which the next frame starts.
// Configuration (width, height) is written on the cfg channel between items;
// any write restarts the frame. Pixels past the last row and early flush ticks
// are dropped without a result.
// The input is held until every result of the previous item has been loaded into
// the output register. The shared sum and reciprocal-multiply path, used once per
// result, and the single line store read port set the pace of the block.
// A result passes a read state (the first flush tick also a drain prime
// state), the sum, multiply and emit states. The output register holds a beat
// while the receiver stalls, and the controller waits before loading the next one.
// Reset clears position and registers to a width of 1024 and a height of 768.
module box_blur_3x3_edge_clipped_unit import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
  input  logic                  s_axis_tuser,   // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  bb3_cmd_t      cmd;
  bb3_status_t   status;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Sequencing and frame position.
  bb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  // Storage and arithmetic.
  bb3_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .in_pixel_i  (s_axis_tdata),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: design/bb3_checker.sv
// Port-level checks of the 3x3 box blur unit, bound to its top level.
`include "box_blur_3x3_edge_clipped_unit_defines.svh"

module bb3_checker import bb3_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o
);

  // A stalled output beat holds its payload.
  `BB3_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")

  // The input is only taken when the controller could also take a register write.
  `BB3_ASSERT_IMPLIES(a_ready_idle, s_axis_tready, cfg_ready_o, "input ready outside idle")

  // A new output beat is loaded only while the input side is closed.
  `BB3_ASSERT_IMPLIES(a_load_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "output loaded while input open")

  // A register write leaves the block idle.
  `BB3_ASSERT_NEXT(a_cfg_idle, cfg_valid_i && cfg_ready_o, cfg_ready_o, "not idle after register write")

endmodule

bind box_blur_3x3_edge_clipped_unit bb3_checker u_bb3_checker (.*);

FILE: verif/tb_box_blur_3x3_edge_clipped_unit.sv
// Self-checking testbench for the 3x3 edge-clipped box blur unit.
module tb_box_blur_3x3_edge_clipped_unit import bb3_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int RAND_MAX_W    = 8;    // widest random frame; the first frame primes this many columns
  localparam int ITEM_TARGET   = 950;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 30;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    op_e  op;
    rgb_t px;
  } stream_item_t;

  typedef struct packed {
    rgb_t px;
    logic last;
  } blur_beat_t;

  // Block ports.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata   = '0;   // in_red, in_green, in_blue
  logic                  s_axis_tuser   = 1'b0; // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;          // out_red, out_green, out_blue
  logic                  m_axis_tlast;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i    = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Stimulus and scoreboard storage.
  stream_item_t pending_items[$];
  blur_beat_t   blur_due[$];
  stream_item_t next_item;
  bit           in_beat_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  // Predicted block state.
  rgb_t        row_two_up[MAX_W];
  rgb_t        row_one_up[MAX_W];
  rgb_t        win_cells[9];
  int          pos_col;
  int          pos_row;
  int          drain_pos;
  logic [10:0] width_cfg;
  logic [12:0] height_cfg;

  // Run statistics.
  int queued_items   = 0;
  int accepted_items = 0;
  int dropped_items  = 0;
  int checked_beats  = 0;
  int frames_done    = 0;
  int reg_writes     = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  box_blur_3x3_edge_clipped_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Width and height as the block uses them, clamped to the supported range.
  function automatic int used_width();
    int w;
    w = int'(width_cfg);
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int used_height();
    int h;
    h = int'(height_cfg);
    if (h < 1) h = 1;
    if (h > int'(HEIGHT_LIMIT)) h = int'(HEIGHT_LIMIT);
    return h;
  endfunction

  function automatic void restart_frame();
    pos_col   = 0;
    pos_row   = 0;
    drain_pos = 0;
    foreach (win_cells[i]) win_cells[i] = '0;
  endfunction

  // Rounded-half-up mean of the summed channels.
  function automatic blur_beat_t mean_beat(int sr, int sg, int sb, int cnt, logic last);
    blur_beat_t b;
    if (cnt == 0) cnt = 1;
    b.px.red   = 8'((2 * sr + cnt) / (2 * cnt));
    b.px.green = 8'((2 * sg + cnt) / (2 * cnt));
    b.px.blue  = 8'((2 * sb + cnt) / (2 * cnt));
    b.last     = last;
    return b;
  endfunction

  // Mean around window column m; window column k holds image column pos_col-2+k.
  function automatic blur_beat_t window_beat(int m, int w);
    int   sr = 0, sg = 0, sb = 0, cnt = 0;
    int   k, c;
    rgb_t nb_px;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dk = -1; dk <= 1; dk++) begin
        k = m + dk;
        c = pos_col - 2 + k;
        if (k <= 2 && c >= 0 && c < w && (dr != 0 || pos_row >= 2)) begin
          nb_px = win_cells[dr * 3 + k];
          sr += nb_px.red;
          sg += nb_px.green;
          sb += nb_px.blue;
          cnt++;
        end
      end
    end
    return mean_beat(sr, sg, sb, cnt, 1'b0);
  endfunction

  // Mean for the last row, taken from the two line stores.
  function automatic blur_beat_t drain_beat(int w, int h, logic last);
    int   sr = 0, sg = 0, sb = 0, cnt = 0;
    int   c;
    rgb_t nb_px;
    for (int dr = 0; dr < 2; dr++) begin
      for (int dk = -1; dk <= 1; dk++) begin
        c = drain_pos + dk;
        if (c >= 0 && c < w && (dr != 0 || h >= 2)) begin
          nb_px = (dr == 0) ? row_two_up[c] : row_one_up[c];
          sr += nb_px.red;
          sg += nb_px.green;
          sb += nb_px.blue;
          cnt++;
        end
      end
    end
    return mean_beat(sr, sg, sb, cnt, last);
  endfunction

  // Predict the blurred beats caused by one accepted stream beat.
  function automatic void predict_blur(stream_item_t it);
    int   w, h, c;
    logic last;
    w = used_width();
    h = used_height();
    if (it.op == OP_FLUSH) begin
      // Flush ticks count only once the whole frame is in.
      if (pos_row < h || drain_pos >= w) begin
        dropped_items++;
        return;
      end
      last = (drain_pos + 1 == w);
      blur_due.push_back(drain_beat(w, h, last));
      drain_pos++;
      if (last) begin
        frames_done++;
        restart_frame();
      end
      return;
    end
    // Pixels past the last row are ignored until the drain completes.
    if (pos_row >= h || pos_col >= w) begin
      dropped_items++;
      return;
    end
    c = pos_col;
    for (int r = 0; r < 3; r++) begin
      win_cells[r * 3]     = win_cells[r * 3 + 1];
      win_cells[r * 3 + 1] = win_cells[r * 3 + 2];
    end
    win_cells[2]  = row_two_up[c];
    win_cells[5]  = row_one_up[c];
    win_cells[8]  = it.px;
    row_two_up[c] = row_one_up[c];
    row_one_up[c] = it.px;
    if (pos_row >= 1) begin
      if (c >= 1) blur_due.push_back(window_beat(1, w));
      if (c + 1 == w) blur_due.push_back(window_beat(2, w));
    end
    if (c + 1 == w) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  function automatic void predict_config(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_cfg = value[10:0];
    end else begin
      height_cfg = value;
    end
    restart_frame();
  endfunction

  function automatic void note_failure();
    fail_count++;
  endfunction

  // Track accepted input and configuration beats and feed the predictor.
  always @(posedge clk_i) begin
    in_beat_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_beat_taken = 1'b1;
        accepted_items++;
        predict_blur('{op: op_e'(s_axis_tuser),
                       px: '{red: s_axis_tdata[7:0], green: s_axis_tdata[15:8],
                             blue: s_axis_tdata[23:16]}});
      end
      if (cfg_valid_i && cfg_ready_o) begin
        predict_config(cfg_index_e'(cfg_index_i), cfg_data_i);
      end
    end
  end

  // Drive the stream input and the output ready at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_beat_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_item.op;
          s_axis_tdata  <= {next_item.px.blue, next_item.px.green, next_item.px.red};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each blurred beat with the oldest prediction.
  always @(posedge clk_i) begin
    blur_beat_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      checked_beats++;
      got.px.red   = m_axis_tdata[7:0];
      got.px.green = m_axis_tdata[15:8];
      got.px.blue  = m_axis_tdata[23:16];
      got.last     = m_axis_tlast;
      if (blur_due.size() == 0) begin
        note_failure();
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected blurred beat: r=%h g=%h b=%h last=%b",
                   got.px.red, got.px.green, got.px.blue, got.last);
        end
      end else begin
        want = blur_due.pop_front();
        if (got != want) begin
          note_failure();
          if (fail_count <= REPORT_LIMIT) begin
            $display("beat %0d mismatch: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                     checked_beats, want.px.red, want.px.green, want.px.blue, want.last,
                     got.px.red, got.px.green, got.px.blue, got.last);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted anywhere.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no beat accepted for %0d cycles, %0d predictions outstanding",
                   QUIET_LIMIT, blur_due.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] random_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t random_rgb();
    rgb_t p;
    p.red   = random_channel();
    p.green = random_channel();
    p.blue  = random_channel();
    return p;
  endfunction

  // Beats that the block is meant to drop are queued with counted low.
  function automatic void queue_item(op_e op, rgb_t px, bit counted);
    pending_items.push_back('{op: op, px: px});
    if (counted) queued_items++;
  endfunction

  // One well-formed frame, optionally with an early flush and surplus pixels.
  function automatic void queue_frame(int w, int h, bit noisy);
    int early_at;
    early_at = (noisy && $urandom_range(3) == 0) ? $urandom_range(w * h - 1) : -1;
    for (int i = 0; i < w * h; i++) begin
      if (i == early_at) queue_item(OP_FLUSH, '0, 1'b0);
      queue_item(OP_PIXEL, random_rgb(), 1'b1);
    end
    if (noisy && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) queue_item(OP_PIXEL, random_rgb(), 1'b0);
    end
    for (int i = 0; i < w; i++) queue_item(OP_FLUSH, random_rgb(), 1'b1);
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  // Hold the sender until every prediction has arrived and the block settles.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || blur_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_pacing(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endfunction

  initial begin
    rgb_t        px;
    int          w, h, group;
    logic [12:0] wval, hval;

    foreach (row_two_up[i]) begin
      row_two_up[i] = '0;
      row_one_up[i] = '0;
    end
    width_cfg  = WIDTH_RESET;
    height_cfg = HEIGHT_RESET;
    restart_frame();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_pacing(0);

    // Full 8x2 frame with extreme channel values; it also fills both line
    // stores for every column that later frames read. One early flush and one
    // surplus pixel ride along and must be dropped.
    write_reg(CFG_IMAGE_WIDTH, 13'd8);
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    for (int i = 0; i < 2 * RAND_MAX_W; i++) begin
      case (i % 4)
        0:       px = '0;
        1:       px = '1;
        2:       px = '{red: 8'hA5, green: 8'h5A, blue: 8'h80};
        default: px = random_rgb();
      endcase
      if (i == 5) queue_item(OP_FLUSH, '0, 1'b0);
      queue_item(OP_PIXEL, px, 1'b1);
    end
    queue_item(OP_PIXEL, '1, 1'b0);
    for (int i = 0; i < RAND_MAX_W; i++) queue_item(OP_FLUSH, '1, 1'b1);
    wait_quiet();

    // Zero width and height act as a 1x1 frame: the mean is the pixel itself.
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    queue_item(OP_PIXEL, random_rgb(), 1'b1);
    queue_item(OP_PIXEL, random_rgb(), 1'b0);
    queue_item(OP_FLUSH, '0, 1'b1);
    wait_quiet();

    // Oversized registers clamp to the largest frame; a partial row and an
    // early flush give nothing, and the next write restarts the frame.
    write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    queue_item(OP_PIXEL, random_rgb(), 1'b1);
    queue_item(OP_PIXEL, random_rgb(), 1'b1);
    queue_item(OP_FLUSH, '0, 1'b0);
    wait_quiet();
    write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
    write_reg(CFG_IMAGE_WIDTH, 13'd1024);
    queue_item(OP_PIXEL, random_rgb(), 1'b1);
    wait_quiet();

    // Random frames, a new size per group and pacing rotated per group.
    group = 0;
    while (queued_items < ITEM_TARGET) begin
      set_pacing(group);
      w = $urandom_range(1, RAND_MAX_W);
      h = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      wval = 13'(w) | 13'($urandom_range(3) << 11);
      hval = 13'(h);
      if ($urandom_range(15) == 0) begin
        wval = '0;
        w = 1;
      end
      if ($urandom_range(15) == 0) begin
        hval = '0;
        h = 1;
      end
      if ($urandom_range(1) == 0) begin
        write_reg(CFG_IMAGE_WIDTH, wval);
        write_reg(CFG_IMAGE_HEIGHT, hval);
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, hval);
        write_reg(CFG_IMAGE_WIDTH, wval);
      end
      repeat ($urandom_range(1, 3)) queue_frame(w, h, 1'b1);
      // Now and then a frame is cut short; the next write restarts it.
      if (w * h > 1 && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, w * h - 1)) queue_item(OP_PIXEL, random_rgb(), 1'b1);
      end
      wait_quiet();
      group++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d stream beats (%0d dropped as surplus or early flush), %0d blurred beats, %0d whole frames.",
             accepted_items, dropped_items, checked_beats, frames_done);
    $display("Used %0d register writes over %0d size groups, sizes 1x1 up to clamped 1024x4096, four pacing mixes.",
             reg_writes, group);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bb3_pkg.sv
design/bb3_ctrl.sv
design/bb3_datapath.sv
design/box_blur_3x3_edge_clipped_unit.sv
design/bb3_checker.sv
verif/tb_box_blur_3x3_edge_clipped_unit.sv
